// ===== rtl/core/deadline_timer_queue_defines.svh =====
// Assertion macros for the deadline timer queue.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define DTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must hold in the cycle after its trigger.
`define DTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DTQ_ASSERT(label, clk, rst, prop, msg)
`define DTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/dtq_pkg.sv =====
// Shared types and codes of the deadline timer queue.
// Used by deadline_timer_queue; depends on nothing.
package dtq_pkg;

   localparam int TIME_W    = 32;
   localparam int DELAY_W   = 31;
   localparam int OUT_LIMIT = 16;
   localparam int K_W       = $clog2(OUT_LIMIT + 1);

   localparam logic [TIME_W-1:0] KEY_BIAS = 32'h8000_0000;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_FAIL = 1'b1;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_REMOVE,
      KIND_EXPIRE
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_WRITE,
      ST_FIND,
      ST_SHIFT_DOWN,
      ST_TICK,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/deadline_timer_queue.sv =====
// Deadline timer queue top level; uses dtq_pkg, dtq_slot_ram and the defines header.
// An add scans for its slot, shifts any later entries up and writes the new one; on a full
// table it fails at once. A remove finds the entry and shifts later entries down. A tick
// drops due entries from the head, at most OUT_LIMIT of them. One item is in work at a
// time, and result stalls can hold it. Reset (synchronous) empties the table by clearing
// the fill count; no clearing pass.
`include "deadline_timer_queue_defines.svh"

module deadline_timer_queue #(
   parameter int SLOTS   = 16,
   parameter int ID_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_op,
   input  logic [ID_BITS-1:0]          req_timer_id,
   input  logic [dtq_pkg::DELAY_W-1:0] req_delay_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_kind,
   output logic [ID_BITS-1:0]          rsp_result_id,
   output logic                        rsp_status,
   output logic                        rsp_last
);

   // The table is a ring in the slot memory. Logical entry 0 (the earliest
   // deadline) sits at head_ff, and the count_ff valid entries follow it.
   // Dropping the head on expiry is then just a pointer move; adds and
   // removes shift the tail of the ring one entry per cycle.
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ENT_W = dtq_pkg::TIME_W + ID_BITS;

   dtq_pkg::state_type state_ff, state_in;

   logic [dtq_pkg::TIME_W-1:0]  time_ff, time_in;
   logic [IDX_W-1:0]            head_ff, head_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            pos_ff, pos_in;
   logic [ID_BITS-1:0]          id_ff, id_in;
   logic [dtq_pkg::DELAY_W-1:0] delay_ff, delay_in;
   dtq_pkg::kind_type           kind_ff, kind_in;
   logic                        status_ff, status_in;
   logic [dtq_pkg::K_W-1:0]     k_ff, k_in;
   logic                        have_pend_ff, have_pend_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   dtq_pkg::kind_type           rsp_kind_ff, rsp_kind_in;
   logic [ID_BITS-1:0]          rsp_id_ff, rsp_id_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic [ENT_W-1:0]            rd_data;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [ENT_W-1:0]            wr_data;

   logic                        push;
   dtq_pkg::kind_type           push_kind;
   logic [ID_BITS-1:0]          push_id;
   logic                        push_status;
   logic                        push_last;

   logic                        req_accept;
   logic                        tick_accept;
   logic                        out_free;
   logic [dtq_pkg::TIME_W-1:0]  rd_deadline;
   logic [ID_BITS-1:0]          rd_owner;
   logic [dtq_pkg::TIME_W-1:0]  rd_key;
   logic [dtq_pkg::TIME_W-1:0]  new_key;
   logic                        le_new;
   logic                        due;
   logic                        id_match;
   logic [CNT_W-1:0]            idx_next;
   logic                        at_end;
   logic [CNT_W-1:0]            count_dec;
   logic                        table_full;
   logic [dtq_pkg::K_W-1:0]     k_next;
   logic                        k_full;
   logic                        take;
   logic [IDX_W-1:0]            head_wrap;

   // Physical slot of a logical entry: head plus offset, folded once.
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, ofs};
      if (sum >= (CNT_W + 1)'(SLOTS)) begin
         sum = sum - (CNT_W + 1)'(SLOTS);
      end
      return sum[IDX_W-1:0];
   endfunction

   dtq_slot_ram #(
      .DEPTH  (SLOTS),
      .WIDTH  (ENT_W),
      .ADDR_W (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_stall   = (state_ff != dtq_pkg::ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign tick_accept = req_accept && (req_op == dtq_pkg::OP_TICK);

   // The output register can take a new item when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rd_deadline = rd_data[ENT_W-1:ID_BITS];
   assign rd_owner    = rd_data[ID_BITS-1:0];

   // Entries are ordered by their signed distance from now. Biasing by the
   // sign bit makes an unsigned compare give that order. For the entry being
   // added the distance is just the delay, which is never negative.
   assign rd_key   = (rd_deadline - time_ff) ^ dtq_pkg::KEY_BIAS;
   assign new_key  = {1'b1, delay_ff};
   assign le_new   = (rd_key <= new_key);
   assign due      = (rd_key <= dtq_pkg::KEY_BIAS);
   assign id_match = (rd_owner == id_ff);

   assign idx_next   = idx_ff + 1'b1;
   assign at_end     = (idx_next == count_ff);
   assign count_dec  = count_ff - 1'b1;
   assign table_full = (count_ff == CNT_W'(SLOTS));
   assign k_next     = k_ff + 1'b1;
   assign k_full     = (k_next == dtq_pkg::K_W'(dtq_pkg::OUT_LIMIT));
   assign head_wrap  = phys(head_ff, CNT_W'(1));

   // During a tick the head entry is taken once the previous expiry, which
   // waits in id_ff until we know whether it is the final one, can be sent.
   assign take = due && (!have_pend_ff || out_free);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtq_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  dtq_pkg::OP_ADD: begin
                     if (table_full) begin
                        state_in = dtq_pkg::ST_EMIT;
                     end else if (count_ff == '0) begin
                        state_in = dtq_pkg::ST_WRITE;
                     end else begin
                        state_in = dtq_pkg::ST_SCAN;
                     end
                  end
                  dtq_pkg::OP_REMOVE: begin
                     state_in = (count_ff == '0) ? dtq_pkg::ST_EMIT : dtq_pkg::ST_FIND;
                  end
                  dtq_pkg::OP_TICK: begin
                     state_in = (count_ff == '0) ? dtq_pkg::ST_IDLE : dtq_pkg::ST_TICK;
                  end
                  default: begin
                     state_in = dtq_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         dtq_pkg::ST_SCAN: begin
            if (!le_new) begin
               state_in = dtq_pkg::ST_SHIFT_UP;
            end else if (at_end) begin
               state_in = dtq_pkg::ST_WRITE;
            end
         end
         dtq_pkg::ST_SHIFT_UP: begin
            if (idx_ff == pos_ff) begin
               state_in = dtq_pkg::ST_WRITE;
            end
         end
         dtq_pkg::ST_WRITE: begin
            state_in = dtq_pkg::ST_EMIT;
         end
         dtq_pkg::ST_FIND: begin
            if (id_match) begin
               state_in = at_end ? dtq_pkg::ST_EMIT : dtq_pkg::ST_SHIFT_DOWN;
            end else if (at_end) begin
               state_in = dtq_pkg::ST_EMIT;
            end
         end
         dtq_pkg::ST_SHIFT_DOWN: begin
            if (at_end) begin
               state_in = dtq_pkg::ST_EMIT;
            end
         end
         dtq_pkg::ST_TICK: begin
            if (!due && (!have_pend_ff || out_free)) begin
               state_in = dtq_pkg::ST_IDLE;
            end else if (take && (k_full || count_ff == CNT_W'(1))) begin
               state_in = dtq_pkg::ST_EMIT;
            end
         end
         dtq_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = dtq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtq_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, memory and output controls.
   always_comb begin
      time_in      = time_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      id_in        = id_ff;
      delay_in     = delay_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      k_in         = k_ff;
      have_pend_in = have_pend_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = rd_data;
      push         = 1'b0;
      push_kind    = kind_ff;
      push_id      = id_ff;
      push_status  = status_ff;
      push_last    = 1'b1;

      case (state_ff)
         dtq_pkg::ST_IDLE: begin
            if (req_accept) begin
               id_in        = req_timer_id;
               delay_in     = req_delay_ms;
               idx_in       = '0;
               pos_in       = '0;
               k_in         = '0;
               have_pend_in = 1'b0;
               case (req_op)
                  dtq_pkg::OP_ADD: begin
                     kind_in   = dtq_pkg::KIND_ADD;
                     status_in = table_full ? dtq_pkg::STAT_FAIL : dtq_pkg::STAT_OK;
                     rd_en     = !table_full && (count_ff != '0);
                  end
                  dtq_pkg::OP_REMOVE: begin
                     kind_in   = dtq_pkg::KIND_REMOVE;
                     status_in = dtq_pkg::STAT_FAIL;
                     rd_en     = (count_ff != '0);
                  end
                  dtq_pkg::OP_TICK: begin
                     kind_in   = dtq_pkg::KIND_EXPIRE;
                     status_in = dtq_pkg::STAT_OK;
                     time_in   = time_ff + 1'b1;
                     rd_en     = (count_ff != '0);
                  end
                  default: begin
                     rd_en = 1'b0;
                  end
               endcase
            end
         end
         dtq_pkg::ST_SCAN: begin
            // Walk forward past every entry that is due no later than the new one.
            if (le_new) begin
               if (at_end) begin
                  pos_in = count_ff;
               end else begin
                  idx_in  = idx_next;
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, idx_next);
               end
            end else begin
               pos_in  = idx_ff;
               idx_in  = count_dec;
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, count_dec);
            end
         end
         dtq_pkg::ST_SHIFT_UP: begin
            // Move the tail up by one, last entry first, to open the insert slot.
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, idx_next);
            wr_data = rd_data;
            if (idx_ff != pos_ff) begin
               idx_in  = idx_ff - 1'b1;
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, idx_ff - 1'b1);
            end
         end
         dtq_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = phys(head_ff, pos_ff);
            wr_data  = {time_ff + {1'b0, delay_ff}, id_ff};
            count_in = count_ff + 1'b1;
         end
         dtq_pkg::ST_FIND: begin
            if (id_match) begin
               status_in = dtq_pkg::STAT_OK;
               if (at_end) begin
                  count_in = count_dec;
               end else begin
                  idx_in  = idx_next;
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, idx_next);
               end
            end else if (!at_end) begin
               idx_in  = idx_next;
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, idx_next);
            end
         end
         dtq_pkg::ST_SHIFT_DOWN: begin
            // Close the gap: each later entry moves down by one.
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, idx_ff - 1'b1);
            wr_data = rd_data;
            if (at_end) begin
               count_in = count_dec;
            end else begin
               idx_in  = idx_next;
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, idx_next);
            end
         end
         dtq_pkg::ST_TICK: begin
            if (have_pend_ff && out_free) begin
               push        = 1'b1;
               push_kind   = dtq_pkg::KIND_EXPIRE;
               push_id     = id_ff;
               push_status = dtq_pkg::STAT_OK;
               push_last   = !due;
               have_pend_in = 1'b0;
            end
            if (take) begin
               id_in    = rd_owner;
               head_in  = head_wrap;
               count_in = count_dec;
               k_in     = k_next;
               if (k_full || count_ff == CNT_W'(1)) begin
                  have_pend_in = 1'b0;
               end else begin
                  have_pend_in = 1'b1;
                  rd_en        = 1'b1;
                  rd_addr      = head_wrap;
               end
            end
         end
         dtq_pkg::ST_EMIT: begin
            push = out_free;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = push_kind;
         rsp_id_in     = push_id;
         rsp_status_in = push_status;
         rsp_last_in   = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtq_pkg::ST_IDLE;
         time_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      id_ff         <= id_in;
      delay_ff      <= delay_in;
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // The fill count never passes the table size.
   `DTQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(SLOTS), "fill count over size")
   // A result is never loaded over one that is still stalled.
   `DTQ_ASSERT(a_push_free, clock, reset, !push || !rsp_valid_ff || !rsp_stall, "result lost")
   // No expiry is left waiting once the block is idle again.
   `DTQ_ASSERT(a_idle_no_pend, clock, reset, state_ff != dtq_pkg::ST_IDLE || !have_pend_ff, "stale")
   // One tick never sends more expiries than the limit.
   `DTQ_ASSERT(a_tick_limit, clock, reset, k_ff <= dtq_pkg::K_W'(dtq_pkg::OUT_LIMIT), "too many")
   // An accepted tick advances the clock by exactly one millisecond.
   `DTQ_ASSERT_NEXT(a_tick_time, clock, reset, tick_accept, time_ff == $past(time_ff) + 32'd1, "tick")

endmodule

// ===== rtl/core/dtq_slot_ram.sv =====
// Slot memory of the deadline timer queue: one write port, one read port.
// Read data is registered; no dependencies.
module dtq_slot_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 40,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
